/* rtl/minmax_peak_decimator_macros.svh */
// Assertion macros used by the minmax_peak_decimator controller (mmpd_ctrl).
// Each macro expects clk and arst_n in the scope of its use.
`ifndef MINMAX_PEAK_DECIMATOR_MACROS_SVH
`define MINMAX_PEAK_DECIMATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define MMPD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MMPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/mmpd_pkg.sv */
// Shared types, constants and the reciprocal table of the min/max peak decimator.
// No dependencies; used by every module under rtl/.
`timescale 1ns / 1ps

package mmpd_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int MAX_CHANNELS   = 8;
	localparam int MAX_BUCKETS    = 8192;
	localparam int MAX_RUN        = 64;

	localparam int CHAN_SEL_BITS  = $clog2(MAX_CHANNELS);
	localparam int SUM_BITS       = SAMPLE_BITS + CHAN_SEL_BITS;
	localparam int RECIP_SHIFT    = SUM_BITS + CHAN_SEL_BITS;
	localparam int RECIP_BITS     = RECIP_SHIFT + 1;
	localparam int PROD_BITS      = SUM_BITS + RECIP_BITS;

	localparam int FRAME_BITS     = 31;
	localparam int COUNT_BITS     = 14;
	localparam int BUCKET_BITS    = 13;
	localparam int CHAN_REG_BITS  = 4;
	localparam int CFG_DATA_BITS  = 31;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_BUCKET_COUNT  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLIP_FRAMES   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          restart;
	} in_item_t;

	typedef struct packed {
		logic [BUCKET_BITS-1:0]        bucket_index;
		logic signed [SAMPLE_BITS-1:0] bucket_min;
		logic [SAMPLE_BITS-2:0]        bucket_max;
		logic                          run_last;
		logic                          clip_done;
		logic                          count_limited;
	} out_item_t;

	typedef struct packed {
		logic take;
		logic clip_start;
		logic open_step;
		logic open_fold;
		logic accumulate;
		logic multiply;
		logic fold;
		logic close;
		logic out_load;
		logic run_last;
		logic frame_inc;
	} cmd_t;

	typedef struct packed {
		logic need_start;
		logic div_done;
		logic frame_done;
		logic close_hit;
		logic last_bucket;
		logic hold_done;
	} status_t;

	// ceil(2^RECIP_SHIFT / d) for d = code + 1; exact floor division for any sum magnitude
	function automatic logic [RECIP_BITS-1:0] recip(input logic [CHAN_SEL_BITS-1:0] code);
		logic [RECIP_BITS-1:0] r;
		unique case (code)
			3'd0: r = 31'd1073741824;
			3'd1: r = 31'd536870912;
			3'd2: r = 31'd357913942;
			3'd3: r = 31'd268435456;
			3'd4: r = 31'd214748365;
			3'd5: r = 31'd178956971;
			3'd6: r = 31'd153391690;
			3'd7: r = 31'd134217728;
			default: r = 31'd1073741824;
		endcase
		return r;
	endfunction

endpackage

/* rtl/mmpd_div.sv */
// Restoring divider, one quotient bit per cycle: frames / buckets at clip start.
// Depends on mmpd_pkg for the field widths.
`timescale 1ns / 1ps

module mmpd_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [mmpd_pkg::FRAME_BITS-1:0]  dividend,
	input  logic [mmpd_pkg::COUNT_BITS-1:0]  divisor,
	output logic                             done,
	output logic [mmpd_pkg::FRAME_BITS-1:0]  quotient,
	output logic [mmpd_pkg::BUCKET_BITS-1:0] remainder
);

	localparam int QW = mmpd_pkg::FRAME_BITS;
	localparam int RW = mmpd_pkg::BUCKET_BITS;
	localparam int CW = $clog2(QW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [QW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [mmpd_pkg::COUNT_BITS-1:0] dvs_q;

	logic [RW:0]   shifted;
	logic          fits;
	logic [RW:0]   diff;

	always_comb begin
		shifted = {rem_q, quo_q[QW-1]};
		fits    = shifted >= (RW+1)'(dvs_q);
		diff    = shifted - (RW+1)'(dvs_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so it fits the narrow register
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QW-2:0], fits};
			rem_q <= fits ? diff[RW-1:0] : shifted[RW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

/* rtl/mmpd_dp.sv */
// Datapath: config registers, channel accumulator, mono divide, min/max, bucket bounds.
// Depends on mmpd_pkg and mmpd_div; driven by mmpd_ctrl through cmd_t and status_t.
`timescale 1ns / 1ps

module mmpd_dp #(
	parameter int MAX_RUN = mmpd_pkg::MAX_RUN
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [mmpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mmpd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  mmpd_pkg::in_item_t                  in_data,
	input  mmpd_pkg::cmd_t                      cmd,
	output mmpd_pkg::status_t                   status,
	output mmpd_pkg::out_item_t                 out_data
);

	localparam int SB  = mmpd_pkg::SAMPLE_BITS;
	localparam int SW  = mmpd_pkg::SUM_BITS;
	localparam int FW  = mmpd_pkg::FRAME_BITS;
	localparam int CNW = mmpd_pkg::COUNT_BITS;
	localparam int BW  = mmpd_pkg::BUCKET_BITS;
	localparam int CSW = mmpd_pkg::CHAN_SEL_BITS;
	localparam int CRW = mmpd_pkg::CHAN_REG_BITS;
	localparam int PW  = mmpd_pkg::PROD_BITS;
	localparam int RS  = mmpd_pkg::RECIP_SHIFT;
	localparam int LW  = FW + $clog2(MAX_RUN + 1);

	// configuration registers
	logic [CNW-1:0] reg_buckets_q;
	logic [FW-1:0]  reg_frames_q;
	logic [CRW-1:0] reg_channels_q;

	// clip state
	logic                 active_q;
	logic                 limited_q;
	logic [CNW-1:0]       eff_buckets_q;
	logic [CSW-1:0]       eff_chm1_q;
	logic signed [SB-1:0] sample_q;
	logic signed [SW-1:0] sum_q;
	logic [CSW-1:0]       seen_q;
	logic [FW-1:0]        frame_q;
	logic [BW-1:0]        bucket_q;
	logic signed [SB-1:0] min_q;
	logic signed [SB-1:0] max_q;
	logic signed [SB-1:0] mono_q;
	logic [FW-1:0]        bucket_end_q;
	logic [FW-1:0]        qraw_q;
	logic [BW-1:0]        rem_q;
	logic [PW-1:0]        prod_s1;
	logic                 neg_s1;

	// result waiting for the output register
	logic [BW-1:0]        hold_idx_q;
	logic signed [SB-1:0] hold_min_q;
	logic [SB-2:0]        hold_max_q;
	logic                 hold_done_q;
	mmpd_pkg::out_item_t  out_q;

	// divider results: frames per bucket and leftover
	logic          div_done;
	logic [FW-1:0] div_quo;
	logic [BW-1:0] div_rem;

	logic [CNW-1:0]       b_clamp;
	logic [FW-1:0]        n_eff;
	logic [LW-1:0]        limit;
	logic                 limit_hit;
	logic [CNW-1:0]       b_eff;
	logic [CSW-1:0]       ch_m1;
	logic signed [SW-1:0] sum_new;
	logic [SW-1:0]        abs_sum;
	logic [PW-RS-1:0]     quo_mag;
	logic [PW-RS-1:0]     quo_signed;
	logic signed [SB-1:0] mono_c;
	logic signed [SB-1:0] fold_v;
	logic [BW:0]          rem_sum;
	logic                 carry;
	logic [BW-1:0]        rem_next;
	logic [FW-1:0]        q_next;
	logic [FW-1:0]        end_next;
	logic                 lo_is_frame;

	mmpd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.clip_start),
		.dividend  (n_eff),
		.divisor   (b_eff),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		if (reg_buckets_q == '0) begin
			b_clamp = CNW'(1);
		end else if (reg_buckets_q > CNW'(mmpd_pkg::MAX_BUCKETS)) begin
			b_clamp = CNW'(mmpd_pkg::MAX_BUCKETS);
		end else begin
			b_clamp = reg_buckets_q;
		end
		n_eff     = (reg_frames_q == '0) ? FW'(1) : reg_frames_q;
		limit     = LW'(MAX_RUN) * LW'(n_eff);
		limit_hit = LW'(b_clamp) > limit;
		b_eff     = limit_hit ? limit[CNW-1:0] : b_clamp;
		if (reg_channels_q == '0) begin
			ch_m1 = '0;
		end else if (reg_channels_q > CRW'(mmpd_pkg::MAX_CHANNELS)) begin
			ch_m1 = CSW'(mmpd_pkg::MAX_CHANNELS - 1);
		end else begin
			ch_m1 = CSW'(reg_channels_q - CRW'(1));
		end
	end

	// accumulate and divide by the channel count through the reciprocal
	always_comb begin
		sum_new    = sum_q + SW'(sample_q);
		abs_sum    = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
		quo_mag    = prod_s1[PW-1:RS];
		quo_signed = neg_s1 ? ((PW-RS)'(0) - quo_mag) : quo_mag;
		mono_c     = signed'(quo_signed[SB-1:0]);
		fold_v     = cmd.fold ? mono_c : mono_q;
	end

	// next bucket bounds from the running remainder
	always_comb begin
		rem_sum     = (BW+1)'(rem_q) + (BW+1)'(div_rem);
		carry       = rem_sum >= (BW+1)'(eff_buckets_q);
		rem_next    = carry ? BW'(rem_sum - (BW+1)'(eff_buckets_q)) : rem_sum[BW-1:0];
		q_next      = qraw_q + div_quo + FW'(carry);
		end_next    = (q_next > qraw_q) ? q_next : qraw_q + FW'(1);
		lo_is_frame = qraw_q == frame_q;
	end

	always_comb begin
		status.need_start  = in_data.restart || !active_q;
		status.div_done    = div_done;
		status.frame_done  = seen_q == eff_chm1_q;
		status.close_hit   = (CNW'(bucket_q) < eff_buckets_q) &&
		                     ((FW+1)'(bucket_end_q) == (FW+1)'(frame_q) + (FW+1)'(1));
		status.last_bucket = (CNW'(bucket_q) + CNW'(1)) == eff_buckets_q;
		status.hold_done   = hold_done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_buckets_q  <= CNW'(1);
			reg_frames_q   <= FW'(1);
			reg_channels_q <= CRW'(1);
			active_q       <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					mmpd_pkg::REG_BUCKET_COUNT:  reg_buckets_q  <= cfg_data[CNW-1:0];
					mmpd_pkg::REG_CLIP_FRAMES:   reg_frames_q   <= cfg_data[FW-1:0];
					mmpd_pkg::REG_CHANNEL_COUNT: reg_channels_q <= cfg_data[CRW-1:0];
					default: ;
				endcase
			end
			if (cmd.clip_start) begin
				active_q <= 1'b1;
			end else if (cmd.close && status.last_bucket) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sample_q <= in_data.sample;
		end
		if (cmd.clip_start) begin
			eff_buckets_q <= b_eff;
			eff_chm1_q    <= ch_m1;
			limited_q     <= limit_hit;
			sum_q         <= '0;
			seen_q        <= '0;
			frame_q       <= '0;
			bucket_q      <= '0;
			min_q         <= '0;
			max_q         <= '0;
			qraw_q        <= '0;
			rem_q         <= '0;
		end
		if (cmd.accumulate) begin
			sum_q  <= sum_new;
			seen_q <= status.frame_done ? '0 : seen_q + CSW'(1);
		end
		if (cmd.multiply) begin
			prod_s1 <= PW'(abs_sum) * PW'(mmpd_pkg::recip(eff_chm1_q));
			neg_s1  <= sum_q[SW-1];
		end
		if (cmd.fold) begin
			mono_q <= mono_c;
			sum_q  <= '0;
		end
		if (cmd.fold || (cmd.open_fold && lo_is_frame)) begin
			if (fold_v < min_q) min_q <= fold_v;
			if (fold_v > max_q) max_q <= fold_v;
		end
		if (cmd.open_step) begin
			qraw_q       <= q_next;
			rem_q        <= rem_next;
			bucket_end_q <= end_next;
		end
		if (cmd.close) begin
			hold_idx_q  <= bucket_q;
			hold_min_q  <= min_q;
			hold_max_q  <= max_q[SB-2:0];
			hold_done_q <= status.last_bucket;
			bucket_q    <= bucket_q + BW'(1);
			min_q       <= '0;
			max_q       <= '0;
		end
		if (cmd.frame_inc) begin
			frame_q <= frame_q + FW'(1);
		end
		if (cmd.out_load) begin
			out_q.bucket_index  <= hold_idx_q;
			out_q.bucket_min    <= hold_min_q;
			out_q.bucket_max    <= hold_max_q;
			out_q.run_last      <= cmd.run_last;
			out_q.clip_done     <= hold_done_q;
			out_q.count_limited <= limited_q;
		end
	end

	assign out_data = out_q;

endmodule

/* rtl/mmpd_ctrl.sv */
// Controller: sequences accumulate, divide, fold and bucket close steps; owns out_valid.
// Depends on mmpd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "minmax_peak_decimator_macros.svh"

module mmpd_ctrl #(
	parameter int MAX_RUN = mmpd_pkg::MAX_RUN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  mmpd_pkg::status_t status,
	output mmpd_pkg::cmd_t    cmd
);

	localparam int RUN_BITS = $clog2(MAX_RUN + 1);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_START = 4'd1;
	localparam logic [3:0] ST_DIV   = 4'd2;
	localparam logic [3:0] ST_OPEN0 = 4'd3;
	localparam logic [3:0] ST_ACC   = 4'd4;
	localparam logic [3:0] ST_MUL   = 4'd5;
	localparam logic [3:0] ST_FOLD  = 4'd6;
	localparam logic [3:0] ST_CLOSE = 4'd7;
	localparam logic [3:0] ST_OPEN  = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	logic [3:0]          state_q;
	logic [3:0]          state_d;
	logic [RUN_BITS-1:0] run_cnt_q;
	logic                out_valid_q;
	logic                more;
	logic                out_free;

	always_comb begin
		more     = !status.hold_done && status.close_hit && (run_cnt_q < RUN_BITS'(MAX_RUN));
		out_free = !out_valid_q || out_ready;
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = status.need_start ? ST_START : ST_ACC;
				end
			end
			ST_START: begin
				cmd.clip_start = 1'b1;
				state_d        = ST_DIV;
			end
			ST_DIV: begin
				if (status.div_done) state_d = ST_OPEN0;
			end
			ST_OPEN0: begin
				cmd.open_step = 1'b1;
				state_d       = ST_ACC;
			end
			ST_ACC: begin
				cmd.accumulate = 1'b1;
				state_d        = status.frame_done ? ST_MUL : ST_IDLE;
			end
			ST_MUL: begin
				cmd.multiply = 1'b1;
				state_d      = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (status.close_hit) begin
					state_d = ST_CLOSE;
				end else begin
					cmd.frame_inc = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = status.last_bucket ? ST_EMIT : ST_OPEN;
			end
			ST_OPEN: begin
				cmd.open_step = 1'b1;
				cmd.open_fold = 1'b1;
				state_d       = ST_EMIT;
			end
			ST_EMIT: begin
				// hold the result until the output register frees up
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.run_last = !more;
					if (more) begin
						state_d = ST_CLOSE;
					end else begin
						cmd.frame_inc = 1'b1;
						state_d       = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.fold) begin
				run_cnt_q <= '0;
			end else if (cmd.close) begin
				run_cnt_q <= run_cnt_q + RUN_BITS'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	`MMPD_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready, "input taken while busy")
	`MMPD_ASSERT_SAME(a_no_overwrite, cmd.out_load && out_valid_q, out_ready, "result overwritten before transfer")
	`MMPD_ASSERT_SAME(a_div_done_in_wait, status.div_done, state_q == ST_DIV, "divider finished outside its wait")
	`MMPD_ASSERT_SAME(a_run_bound, 1'b1, run_cnt_q <= RUN_BITS'(MAX_RUN), "run count past its limit")

endmodule

/* rtl/minmax_peak_decimator.sv */
// Min/max peak decimator: takes interleaved signed samples one channel per transfer,
// averages each frame into a mono value (truncated toward zero) and reports, for each
// of the clip's buckets, its index and the lowest and highest mono value, both starting
// at zero. A sample that does not finish a frame is only accumulated; a finished frame
// also passes through the reciprocal multiply, its register and the fold, then closes
// each bucket it ends (close, next-bound update, output load; the clip's final bucket
// needs no next bound), waiting while the output is stalled.
// The first sample of a clip also waits for the 31-step restoring divider
// that splits the frame count over the buckets; bounds after that advance by addition.
// Registers written while idle take effect at the next clip start.
// Depends on mmpd_pkg, mmpd_ctrl, mmpd_dp and mmpd_div.
`timescale 1ns / 1ps

module minmax_peak_decimator #(
	parameter int MAX_RUN = mmpd_pkg::MAX_RUN
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [mmpd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [mmpd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  mmpd_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output mmpd_pkg::out_item_t                 out_data
);

	mmpd_pkg::cmd_t    cmd;
	mmpd_pkg::status_t status;

	mmpd_ctrl #(
		.MAX_RUN (MAX_RUN)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	mmpd_dp #(
		.MAX_RUN (MAX_RUN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule
